// File: hdl/ipv4_header_checker_top_assert.svh
// Assertion macros for the IPv4 header checker checker module.
// Expects signals named clock and reset in the scope of use.
`ifndef IPV4_HEADER_CHECKER_TOP_ASSERT_SVH
`define IPV4_HEADER_CHECKER_TOP_ASSERT_SVH

// implication in the same cycle, off during reset
`define IHC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication in the next cycle, off during reset
`define IHC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// implication in the next cycle, checked through reset
`define IHC_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ihc_pkg.sv
// Shared types and constants of the IPv4 header checker.
// No dependencies; imported by every module of the block.
package ihc_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [1:0]  proto_class;
      logic [31:0] source_address;
      logic [5:0]  header_bytes;
      logic [15:0] payload_bytes;
      logic        was_broadcast;
   } rsp_payload_type;

   // per-packet summary handed from the parser to the verdict stage
   typedef struct packed {
      logic [3:0]  version;
      logic [5:0]  header_len;
      logic [15:0] sum;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] dest;
      logic [15:0] length;
   } pkt_summary_type;

   localparam logic [2:0] VERDICT_DELIVER  = 3'd0;
   localparam logic [2:0] VERDICT_SHORT    = 3'd1;
   localparam logic [2:0] VERDICT_VERSION  = 3'd2;
   localparam logic [2:0] VERDICT_HDR_LEN  = 3'd3;
   localparam logic [2:0] VERDICT_CHECKSUM = 3'd4;
   localparam logic [2:0] VERDICT_NOT_OURS = 3'd5;
   localparam logic [2:0] VERDICT_PROTO    = 3'd6;

   localparam logic [1:0] CLASS_ICMP  = 2'd0;
   localparam logic [1:0] CLASS_UDP   = 2'd1;
   localparam logic [1:0] CLASS_TCP   = 2'd2;
   localparam logic [1:0] CLASS_OTHER = 2'd3;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam logic [5:0]  MIN_HEADER_BYTES = 6'd20;
   localparam logic [3:0]  IPV4_VERSION     = 4'd4;
   localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFF_FFFF;
   localparam logic [15:0] CHECKSUM_GOOD    = 16'hFFFF;
   localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

   // header byte offsets
   localparam logic [15:0] OFS_PROTOCOL = 16'd9;
   localparam logic [15:0] OFS_SRC_LO   = 16'd12;
   localparam logic [15:0] OFS_SRC_HI   = 16'd15;
   localparam logic [15:0] OFS_DST_LO   = 16'd16;
   localparam logic [15:0] OFS_DST_HI   = 16'd19;

endpackage

// File: hdl/ihc_parser.sv
// Front end: takes packet beats, captures header fields and the checksum.
// Depends on ihc_pkg. Emits one summary per packet on the last beat.
module ihc_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     beat_accept,
   input  ihc_pkg::req_payload_type beat,
   output logic                     sum_push,
   output ihc_pkg::pkt_summary_type sum_data
);
   import ihc_pkg::*;

   logic [15:0] count_ff, count_in;
   logic [5:0]  hlen_ff, hlen_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [3:0]  ver_ff, ver_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [16:0] wide_sum;
   logic [7:0]  b;

   always_comb begin
      b        = beat.data_byte;
      ver_in   = ver_ff;
      hlen_in  = hlen_ff;
      sum_in   = sum_ff;
      hold_in  = hold_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      wide_sum = {1'b0, sum_ff} + {1'b0, hold_ff, b};
      if (count_ff == 16'd0) begin
         ver_in  = b[7:4];
         hlen_in = {b[3:0], 2'b00};
      end
      if (count_ff < {10'd0, hlen_in}) begin
         if (!count_ff[0]) begin
            hold_in = b;
         end else begin
            sum_in = wide_sum[15:0] + {15'd0, wide_sum[16]};
         end
      end
      if (count_ff == OFS_PROTOCOL) begin
         proto_in = b;
      end
      if (count_ff >= OFS_SRC_LO && count_ff <= OFS_SRC_HI) begin
         src_in = {src_ff[23:0], b};
      end
      if (count_ff >= OFS_DST_LO && count_ff <= OFS_DST_HI) begin
         dst_in = {dst_ff[23:0], b};
      end
      count_in = (count_ff != COUNT_MAX) ? count_ff + 16'd1 : count_ff;

      sum_push            = beat_accept && beat.last_byte;
      sum_data.version    = ver_in;
      sum_data.header_len = hlen_in;
      sum_data.sum        = sum_in;
      sum_data.protocol   = proto_in;
      sum_data.source     = src_in;
      sum_data.dest       = dst_in;
      sum_data.length     = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset || sum_push) begin
         count_ff <= '0;
         hlen_ff  <= '0;
         sum_ff   <= '0;
         hold_ff  <= '0;
         ver_ff   <= '0;
         proto_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
      end else if (beat_accept) begin
         count_ff <= count_in;
         hlen_ff  <= hlen_in;
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         ver_ff   <= ver_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
      end
   end

endmodule

// File: hdl/ihc_queue.sv
// Small summary queue between the parser and the verdict stage.
// Depends on ihc_pkg for the summary record type.
module ihc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ihc_pkg::pkt_summary_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     pop_valid,
   output ihc_pkg::pkt_summary_type pop_data
);
   import ihc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   pkt_summary_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = (count_ff == FULL_CNT);
      pop_valid = (count_ff != '0);
      pop_data  = entry_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && pop_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/ihc_verdict.sv
// Back end: turns a packet summary into the verdict and result fields.
// Depends on ihc_pkg. Holds the result in an output register.
module ihc_verdict (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [31:0]              local_address,
   input  logic                     sum_valid,
   input  ihc_pkg::pkt_summary_type sum_data,
   output logic                     sum_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ihc_pkg::rsp_payload_type rsp_payload
);
   import ihc_pkg::*;

   logic            valid_ff;
   rsp_payload_type result_ff, result_in;
   logic            bcast;

   always_comb begin
      case (sum_data.protocol)
         PROTO_ICMP: result_in.proto_class = CLASS_ICMP;
         PROTO_UDP:  result_in.proto_class = CLASS_UDP;
         PROTO_TCP:  result_in.proto_class = CLASS_TCP;
         default:    result_in.proto_class = CLASS_OTHER;
      endcase
      bcast = (sum_data.dest == BROADCAST_ADDR);

      if (sum_data.length < {10'd0, MIN_HEADER_BYTES}) begin
         result_in.verdict = VERDICT_SHORT;
      end else if (sum_data.version != IPV4_VERSION) begin
         result_in.verdict = VERDICT_VERSION;
      end else if (sum_data.header_len < MIN_HEADER_BYTES
                   || {10'd0, sum_data.header_len} > sum_data.length) begin
         result_in.verdict = VERDICT_HDR_LEN;
      end else if (sum_data.sum != CHECKSUM_GOOD) begin
         result_in.verdict = VERDICT_CHECKSUM;
      end else if (sum_data.dest != local_address && !bcast) begin
         result_in.verdict = VERDICT_NOT_OURS;
      end else if (result_in.proto_class == CLASS_OTHER) begin
         result_in.verdict = VERDICT_PROTO;
      end else begin
         result_in.verdict = VERDICT_DELIVER;
      end

      result_in.source_address = sum_data.source;
      result_in.header_bytes   = sum_data.header_len;
      result_in.payload_bytes  = (sum_data.length >= {10'd0, sum_data.header_len})
                                 ? sum_data.length - {10'd0, sum_data.header_len} : 16'd0;
      result_in.was_broadcast  = bcast;

      sum_pop     = sum_valid && (!valid_ff || rsp_ready);
      rsp_valid   = valid_ff;
      rsp_payload = result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sum_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_pop) begin
         result_ff <= result_in;
      end
   end

endmodule

// File: hdl/ipv4_header_checker_top.sv
// IPv4 receive header checker, top level.
// Depends on ihc_pkg, ihc_parser, ihc_queue and ihc_verdict.
//
// Takes one packet byte per cycle with no gaps needed between packets. The
// parser keeps the running header checksum and captured fields; on the last
// beat it pushes a packet summary into a QUEUE_DEPTH-entry queue, and the
// verdict stage turns it into a registered result, offered once the summary
// has passed the queue and the verdict output register. Beats keep flowing
// while results wait; input stalls only once the queue is full. The user must
// write local_address via csr_ only while no packet is in flight; not enforced.
module ipv4_header_checker_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ihc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ihc_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic [31:0]              csr_write_data
);
   import ihc_pkg::*;

   logic [31:0]     local_addr_ff;
   logic            beat_accept;
   logic            sum_push, q_full, q_valid, q_pop;
   pkt_summary_type push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
      end else if (csr_write_enable) begin
         local_addr_ff <= csr_write_data;
      end
   end

   assign req_ready   = !q_full;
   assign beat_accept = req_valid && req_ready;

   ihc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .beat        (req_payload),
      .sum_push    (sum_push),
      .sum_data    (push_data)
   );

   ihc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (sum_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (pop_data)
   );

   ihc_verdict u_verdict (
      .clock         (clock),
      .reset         (reset),
      .local_address (local_addr_ff),
      .sum_valid     (q_valid),
      .sum_data      (pop_data),
      .sum_pop       (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

endmodule

// File: hdl/ihc_checker.sv
// Port-level assertions for the IPv4 header checker, bound to the top level.
// Depends on ihc_pkg and ipv4_header_checker_top_assert.svh.
`include "ipv4_header_checker_top_assert.svh"

module ihc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ihc_pkg::rsp_payload_type rsp_payload
);
   import ihc_pkg::*;

   `IHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result changed")
   `IHC_ASSERT_ALWAYS_NEXT(a_reset_idle, reset, !rsp_valid && req_ready, "not idle after reset")
   `IHC_ASSERT_NOW(a_deliver_hdr, rsp_valid && rsp_payload.verdict == VERDICT_DELIVER, rsp_payload.header_bytes >= MIN_HEADER_BYTES && rsp_payload.proto_class != CLASS_OTHER, "delivered packet with bad header or protocol")
   `IHC_ASSERT_NOW(a_bcast_ours, rsp_valid && rsp_payload.verdict == VERDICT_NOT_OURS, !rsp_payload.was_broadcast, "broadcast packet rejected as not ours")

endmodule

bind ipv4_header_checker_top ihc_checker u_ihc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
